FILE: design/uart_line_command_parser_macros.svh
// ---------------------------------------------------------------------------
// uart_line_command_parser_macros.svh
// Assertion macros shared by the line command parser RTL.
// ---------------------------------------------------------------------------
`ifndef UART_LINE_COMMAND_PARSER_MACROS_SVH
`define UART_LINE_COMMAND_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge of clk, quiet while arst_n is low.
`define ULCP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds.
`define ULCP_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ULCP_ASSERT(label, prop, msg)
`define ULCP_NEVER(label, cond, msg)
`endif

`endif

FILE: design/ulcp_pkg.sv
// ---------------------------------------------------------------------------
// ulcp_pkg
// Sizes, codes, keyword strings and shared types of the line command parser.
// ---------------------------------------------------------------------------
package ulcp_pkg;

	localparam int LINE_BYTES   = 128;
	localparam int NAME_CHARS   = 16;
	localparam int EXT_CHARS    = 7;
	localparam int DEVICE_CHARS = 31;
	localparam int FREQ_CHARS   = 7;

	localparam int ADDR_W = $clog2(LINE_BYTES);
	localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(LINE_BYTES - 1);

	localparam int NUM_PFX  = 5;
	localparam int NUM_WORD = 5;

	// prefix indexes, in match priority order
	localparam int PFX_SONG = 0;
	localparam int PFX_CONN = 1;
	localparam int PFX_DISC = 2;
	localparam int PFX_FREQ = 3;
	localparam int PFX_MODE = 4;

	// mode word indexes
	localparam int WORD_USB  = 0;
	localparam int WORD_BT   = 1;
	localparam int WORD_FM   = 2;
	localparam int WORD_LINE = 3;
	localparam int WORD_AUX  = 4;

	localparam logic [2:0] KIND_SONG = 3'd0;
	localparam logic [2:0] KIND_CONN = 3'd1;
	localparam logic [2:0] KIND_DISC = 3'd2;
	localparam logic [2:0] KIND_FREQ = 3'd3;
	localparam logic [2:0] KIND_MODE = 3'd4;

	localparam logic [2:0] PART_NAME   = 3'd0;
	localparam logic [2:0] PART_EXT    = 3'd1;
	localparam logic [2:0] PART_DEVICE = 3'd2;
	localparam logic [2:0] PART_FREQ   = 3'd3;
	localparam logic [2:0] PART_NONE   = 3'd4;

	localparam logic [2:0] SRC_USB     = 3'd0;
	localparam logic [2:0] SRC_BT      = 3'd1;
	localparam logic [2:0] SRC_FM      = 3'd2;
	localparam logic [2:0] SRC_AUX     = 3'd3;
	localparam logic [2:0] SRC_UNKNOWN = 3'd4;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_LC_A = 8'h61;
	localparam logic [7:0] CH_LC_Z = 8'h7A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// keywords, left aligned and padded with zeros
	localparam logic [71:0] STR_SONG = {"SONG:", 32'h0};
	localparam logic [71:0] STR_CONN = {"BT_CONN:", 8'h0};
	localparam logic [71:0] STR_DISC = {"BT_", "DISCON"};
	localparam logic [71:0] STR_FREQ = {"FM_FREQ:", 8'h0};
	localparam logic [71:0] STR_MODE = {"MODE:", 32'h0};

	localparam logic [31:0] STR_USB  = {"USB", 8'h0};
	localparam logic [31:0] STR_BT   = {"BT", 16'h0};
	localparam logic [31:0] STR_FM   = {"FM", 16'h0};
	localparam logic [31:0] STR_LINE = "LINE";
	localparam logic [31:0] STR_AUX  = {"AUX", 8'h0};

	// offset of the text after the mode prefix
	localparam logic [3:0] MODE_TEXT = 4'd5;

	typedef struct packed {
		logic clr;
		logic step;
	} scan_ctl_t;

	typedef struct packed {
		logic [NUM_PFX-1:0]  pfx_ok;
		logic [NUM_WORD-1:0] word_ok;
		logic                dot_seen;
		logic [ADDR_W-1:0]   dot_pos;
	} scan_res_t;

	function automatic logic [3:0] pfx_len(input int p);
		logic [3:0] n;
		case (p)
			PFX_SONG: n = 4'd5;
			PFX_CONN: n = 4'd8;
			PFX_DISC: n = 4'd9;
			PFX_FREQ: n = 4'd8;
			default:  n = 4'd5;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] pfx_char(input int p, input logic [3:0] i);
		logic [71:0] s;
		logic [71:0] t;
		case (p)
			PFX_SONG: s = STR_SONG;
			PFX_CONN: s = STR_CONN;
			PFX_DISC: s = STR_DISC;
			PFX_FREQ: s = STR_FREQ;
			default:  s = STR_MODE;
		endcase
		t = s << {i, 3'b000};
		return t[71:64];
	endfunction

	function automatic logic [2:0] word_len(input int w);
		logic [2:0] n;
		case (w)
			WORD_USB:  n = 3'd3;
			WORD_BT:   n = 3'd2;
			WORD_FM:   n = 3'd2;
			WORD_LINE: n = 3'd4;
			default:   n = 3'd3;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] word_char(input int w, input logic [1:0] j);
		logic [31:0] s;
		logic [31:0] t;
		case (w)
			WORD_USB:  s = STR_USB;
			WORD_BT:   s = STR_BT;
			WORD_FM:   s = STR_FM;
			WORD_LINE: s = STR_LINE;
			default:   s = STR_AUX;
		endcase
		t = s << {j, 3'b000};
		return t[31:24];
	endfunction

endpackage

FILE: design/uart_line_command_parser.sv
// ---------------------------------------------------------------------------
// uart_line_command_parser
// Line buffer and command parser for bytes received from a serial link.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one received byte per transaction in s_tdata[7:0].
//   Ordinary bytes are written to the line store; once LINE_BYTES-1 bytes
//   are held, further ordinary bytes are dropped.
//   CR or LF ends a non-empty line; an empty line is ignored.
//   At line end the block walks the store through the byte compare unit,
//   each stored byte taking a RAM read and then a compare, up to the first
//   zero byte or the end of the line, and then picks the command and sets up
//   the text segments. It then emits the run on the master channel m_*: each
//   text character takes a RAM read and then a load of the output register,
//   and a marker result a single load, with m_tlast on the final result of
//   the run. s_tready stays low from the line end until the last result is
//   loaded.
//   The output register parts the two sides: a stalled receiver holds the
//   current result, and the sequencer waits until the slot is free.
//   Lines that match no command leave the channel untouched.
//   Reset (arst_n low) empties the line and the output register; the store
//   itself is not cleared, as only bytes of the current line are read.
// ---------------------------------------------------------------------------
`include "uart_line_command_parser_macros.svh"

module uart_line_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	// received byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// parsed result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] text_char, [10:8] input_source, [15:11] zero
	output logic [6:0]  m_tuser,   // [2:0] event_kind, [5:3] text_part, [6] char_valid
	output logic        m_tlast    // last
);
	import ulcp_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN_RD  = 3'd1;
	localparam logic [2:0] S_SCAN_CMP = 3'd2;
	localparam logic [2:0] S_SETUP    = 3'd3;
	localparam logic [2:0] S_EMIT_RD  = 3'd4;
	localparam logic [2:0] S_EMIT_OUT = 3'd5;
	localparam logic [2:0] S_MARK     = 3'd6;

	// Cut a span to a character limit.
	function automatic logic [ADDR_W-1:0] clip(input logic [ADDR_W-1:0] span,
			input int limit);
		logic [ADDR_W-1:0] r;
		if (int'(span) > limit) begin
			r = ADDR_W'(limit);
		end else begin
			r = span;
		end
		return r;
	endfunction

	// sequencer state
	logic [2:0]        state_q;
	logic [ADDR_W-1:0] fill_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] len_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [2:0]        kind_q;
	logic [2:0]        part_q;
	logic [2:0]        src_q;
	logic              upper_q;
	logic              has_b_q;
	logic [ADDR_W-1:0] ptr_b_q;
	logic [ADDR_W-1:0] cnt_b_q;

	// output register
	logic       m_tvalid_q;
	logic [2:0] out_kind_q;
	logic [2:0] out_part_q;
	logic       out_cv_q;
	logic [7:0] out_char_q;
	logic [2:0] out_src_q;
	logic       out_last_q;

	logic       in_acc;
	logic       is_eol;
	logic       ram_we;
	logic [7:0] ram_rdata;
	logic       out_free;
	logic       load_out;
	logic [7:0] emit_char;

	scan_ctl_t scan_ctl;
	scan_res_t scan_res;

	// setup decisions
	logic [NUM_PFX-1:0] hit;
	logic [ADDR_W-1:0]  song_end;
	logic [ADDR_W-1:0]  song_ext;
	logic [ADDR_W-1:0]  txt_len;
	logic [2:0]         su_kind;
	logic [2:0]         su_part;
	logic [2:0]         su_src;
	logic               su_any;
	logic               su_mark;
	logic [ADDR_W-1:0]  su_ptr_a;
	logic [ADDR_W-1:0]  su_cnt_a;
	logic [ADDR_W-1:0]  su_ptr_b;
	logic [ADDR_W-1:0]  su_cnt_b;

	assign in_acc   = s_tvalid && s_tready;
	assign is_eol   = (s_tdata == CH_LF) || (s_tdata == CH_CR);
	assign ram_we   = in_acc && !is_eol && (fill_q != FILL_MAX);
	assign s_tready = (state_q == S_IDLE);

	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = ((state_q == S_EMIT_OUT) || (state_q == S_MARK)) && out_free;

	// upper-case the extension on the way out
	assign emit_char = (upper_q && ram_rdata >= CH_LC_A && ram_rdata <= CH_LC_Z)
		? (ram_rdata & ~CASE_BIT) : ram_rdata;

	assign scan_ctl.clr  = in_acc && is_eol && (fill_q != '0);
	assign scan_ctl.step = (state_q == S_SCAN_CMP) && (ram_rdata != CH_NUL);

	ulcp_ram #(
		.WIDTH(8),
		.DEPTH(LINE_BYTES)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (s_tdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	ulcp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.idx    (ptr_q),
		.data   (ram_rdata),
		.res    (scan_res)
	);

	// Pick the command and its text segments once the walk has ended.
	always_comb begin
		for (int p = 0; p < NUM_PFX; p++) begin
			hit[p] = scan_res.pfx_ok[p] && (len_q >= ADDR_W'(pfx_len(p)));
		end
		song_end = scan_res.dot_seen ? scan_res.dot_pos : len_q;
		song_ext = scan_res.dot_seen ? (scan_res.dot_pos + 1'b1) : len_q;
		txt_len  = len_q - ADDR_W'(MODE_TEXT);

		su_kind  = KIND_SONG;
		su_part  = PART_NAME;
		su_src   = SRC_UNKNOWN;
		su_any   = 1'b1;
		su_mark  = 1'b0;
		su_ptr_a = ADDR_W'(pfx_len(PFX_SONG));
		su_cnt_a = '0;
		su_ptr_b = '0;
		su_cnt_b = '0;

		if (hit[PFX_SONG]) begin
			su_cnt_a = clip(song_end - ADDR_W'(pfx_len(PFX_SONG)), NAME_CHARS);
			su_ptr_b = song_ext;
			su_cnt_b = clip(len_q - song_ext, EXT_CHARS);
			su_mark  = (su_cnt_a == '0) && (su_cnt_b == '0);
		end else if (hit[PFX_CONN]) begin
			su_kind  = KIND_CONN;
			su_part  = PART_DEVICE;
			su_ptr_a = ADDR_W'(pfx_len(PFX_CONN));
			su_cnt_a = clip(len_q - ADDR_W'(pfx_len(PFX_CONN)), DEVICE_CHARS);
			su_mark  = (su_cnt_a == '0);
		end else if (hit[PFX_DISC]) begin
			su_kind = KIND_DISC;
			su_part = PART_NONE;
			su_mark = 1'b1;
		end else if (hit[PFX_FREQ]) begin
			su_kind  = KIND_FREQ;
			su_part  = PART_FREQ;
			su_ptr_a = ADDR_W'(pfx_len(PFX_FREQ));
			su_cnt_a = clip(len_q - ADDR_W'(pfx_len(PFX_FREQ)), FREQ_CHARS);
			su_mark  = (su_cnt_a == '0);
		end else if (hit[PFX_MODE]) begin
			su_kind = KIND_MODE;
			su_part = PART_NONE;
			su_mark = 1'b1;
			if (scan_res.word_ok[WORD_USB] && txt_len == ADDR_W'(word_len(WORD_USB))) begin
				su_src = SRC_USB;
			end else if (scan_res.word_ok[WORD_BT]
					&& txt_len == ADDR_W'(word_len(WORD_BT))) begin
				su_src = SRC_BT;
			end else if (scan_res.word_ok[WORD_FM]
					&& txt_len == ADDR_W'(word_len(WORD_FM))) begin
				su_src = SRC_FM;
			end else if ((scan_res.word_ok[WORD_LINE]
					&& txt_len == ADDR_W'(word_len(WORD_LINE)))
					|| (scan_res.word_ok[WORD_AUX]
					&& txt_len == ADDR_W'(word_len(WORD_AUX)))) begin
				su_src = SRC_AUX;
			end
		end else begin
			su_any = 1'b0;
		end
	end

	// Sequencer: fill, walk, set up, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			ptr_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			kind_q  <= KIND_SONG;
			part_q  <= PART_NAME;
			src_q   <= SRC_UNKNOWN;
			upper_q <= 1'b0;
			has_b_q <= 1'b0;
			ptr_b_q <= '0;
			cnt_b_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (is_eol) begin
							if (fill_q != '0) begin
								ptr_q   <= '0;
								state_q <= S_SCAN_RD;
							end
						end else if (fill_q != FILL_MAX) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_SCAN_RD: begin
					// whole line walked: length is the fill
					if (ptr_q == fill_q) begin
						len_q   <= ptr_q;
						state_q <= S_SETUP;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					// a zero byte ends the text
					if (ram_rdata == CH_NUL) begin
						len_q   <= ptr_q;
						state_q <= S_SETUP;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_SETUP: begin
					fill_q  <= '0;
					kind_q  <= su_kind;
					part_q  <= su_part;
					src_q   <= su_src;
					ptr_b_q <= su_ptr_b;
					cnt_b_q <= su_cnt_b;
					if (!su_any) begin
						state_q <= S_IDLE;
					end else if (su_mark) begin
						state_q <= S_MARK;
					end else if (su_cnt_a == '0) begin
						// empty song name: go straight to the extension
						ptr_q   <= su_ptr_b;
						cnt_q   <= su_cnt_b;
						part_q  <= PART_EXT;
						upper_q <= 1'b1;
						has_b_q <= 1'b0;
						state_q <= S_EMIT_RD;
					end else begin
						ptr_q   <= su_ptr_a;
						cnt_q   <= su_cnt_a;
						upper_q <= 1'b0;
						has_b_q <= (su_kind == KIND_SONG) && (su_cnt_b != '0);
						state_q <= S_EMIT_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (out_free) begin
						if (cnt_q == ADDR_W'(1)) begin
							if (has_b_q) begin
								ptr_q   <= ptr_b_q;
								cnt_q   <= cnt_b_q;
								part_q  <= PART_EXT;
								upper_q <= 1'b1;
								has_b_q <= 1'b0;
								state_q <= S_EMIT_RD;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							cnt_q   <= cnt_q - 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_MARK: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: load a result, hold it while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q <= kind_q;
			out_part_q <= part_q;
			out_src_q  <= src_q;
			if (state_q == S_MARK) begin
				out_cv_q   <= 1'b0;
				out_char_q <= CH_NUL;
				out_last_q <= 1'b1;
			end else begin
				out_cv_q   <= 1'b1;
				out_char_q <= emit_char;
				out_last_q <= (cnt_q == ADDR_W'(1)) && !has_b_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_src_q, out_char_q};
	assign m_tuser  = {out_cv_q, out_part_q, out_kind_q};
	assign m_tlast  = out_last_q;

	// A stored byte grows the fill by exactly one.
	`ULCP_ASSERT(a_fill_step, (in_acc && !is_eol && fill_q != FILL_MAX) |=> (fill_q == $past(fill_q) + 1'b1), "fill count did not advance on a stored byte")
	// The walk never passes the end of the stored line.
	`ULCP_ASSERT(a_scan_bound, (state_q == S_SCAN_RD || state_q == S_SCAN_CMP) |-> (ptr_q <= fill_q), "scan pointer beyond the stored line")
	// Emission reads only bytes of the text.
	`ULCP_ASSERT(a_emit_bound, (state_q == S_EMIT_RD || state_q == S_EMIT_OUT) |-> (ptr_q < len_q), "emit pointer beyond the line text")
	// A text segment in flight always has characters left.
	`ULCP_NEVER(a_emit_count, (state_q == S_EMIT_RD || state_q == S_EMIT_OUT) && cnt_q == '0, "emitting with an empty segment")

endmodule

FILE: design/ulcp_ram.sv
// ---------------------------------------------------------------------------
// ulcp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ulcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ulcp_scan.sv
// ---------------------------------------------------------------------------
// ulcp_scan
// Byte compare unit: folds one stored byte a step into the prefix, mode word
// and last-dot trackers.
// ---------------------------------------------------------------------------
module ulcp_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ulcp_pkg::scan_ctl_t           ctl,
	input  logic [ulcp_pkg::ADDR_W-1:0]   idx,
	input  logic [7:0]                    data,
	output ulcp_pkg::scan_res_t           res
);
	import ulcp_pkg::*;

	logic [NUM_PFX-1:0]  pfx_ok_q;
	logic [NUM_WORD-1:0] word_ok_q;
	logic                dot_seen_q;
	logic [ADDR_W-1:0]   dot_pos_q;

	logic [NUM_PFX-1:0]  pfx_miss;
	logic [NUM_WORD-1:0] word_miss;
	logic                in_text;
	logic [ADDR_W-1:0]   txt_idx;

	assign in_text = idx >= ADDR_W'(MODE_TEXT);
	assign txt_idx = idx - ADDR_W'(MODE_TEXT);

	always_comb begin
		for (int p = 0; p < NUM_PFX; p++) begin
			pfx_miss[p] = (idx < ADDR_W'(pfx_len(p))) && (data != pfx_char(p, idx[3:0]));
		end
		for (int w = 0; w < NUM_WORD; w++) begin
			word_miss[w] = in_text && (txt_idx < ADDR_W'(word_len(w)))
				&& (data != word_char(w, txt_idx[1:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_ok_q   <= '0;
			word_ok_q  <= '0;
			dot_seen_q <= 1'b0;
			dot_pos_q  <= '0;
		end else if (ctl.clr) begin
			pfx_ok_q   <= '1;
			word_ok_q  <= '1;
			dot_seen_q <= 1'b0;
		end else if (ctl.step) begin
			pfx_ok_q  <= pfx_ok_q & ~pfx_miss;
			word_ok_q <= word_ok_q & ~word_miss;
			// keep the latest dot of the text
			if (in_text && data == CH_DOT) begin
				dot_seen_q <= 1'b1;
				dot_pos_q  <= idx;
			end
		end
	end

	assign res.pfx_ok   = pfx_ok_q;
	assign res.word_ok  = word_ok_q;
	assign res.dot_seen = dot_seen_q;
	assign res.dot_pos  = dot_pos_q;

endmodule
